/* design/nqse_pkg.sv */
package nqse_pkg;

  localparam int NQ_MAX_N = 8;
  localparam int BOARD_W = 4;
  localparam logic [BOARD_W-1:0] BOARD_RESET = 4'd8;
  localparam int TDATA_W = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK,
    ST_POP,
    ST_OUT_RD,
    ST_OUT_LD,
    ST_HOLD,
    ST_EXH
  } nq_state_t;

endpackage

/* design/n_queens_solution_enumerator_core.sv */
// N-queens enumerator. Each input word asks for the next solution (restart in bit 0 of
// s_tdata starts the search over); the answer is a run of board_size output words, one per
// row with its queen column, tlast on the final row, or one word with tuser set when no
// solution remains. The placed columns live in a one-port-read stack memory, and every
// candidate square is checked against the rows above by reading that memory one entry
// per cycle; each output word is read from that memory, loaded, and then held until
// m_tready takes it. The time a request takes on the full 8 by 8 board is set by that
// serial conflict scan. board_size must be written only while the block is idle; the
// block itself does not enforce this. Sizes above MAX_N are treated as MAX_N.
module n_queens_solution_enumerator_core #(
  parameter int MAX_N = nqse_pkg::NQ_MAX_N
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nqse_pkg::BOARD_W-1:0]   cfg_data,   // board_size
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [nqse_pkg::TDATA_W-1:0]   s_tdata,    // [0] restart, [7:1] zero
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [nqse_pkg::TDATA_W-1:0]   m_tdata,    // [2:0] row_index, [5:3] queen_column
  output logic                           m_tlast,    // last_row
  output logic                           m_tuser     // exhausted
);
  import nqse_pkg::*;

  localparam int ADDR_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int ROW_W  = $clog2(MAX_N + 1);
  localparam int EXT_W  = (ROW_W > BOARD_W) ? ROW_W : BOARD_W;

  nq_state_t state, state_next;

  logic [BOARD_W-1:0] board_size;
  logic [ROW_W-1:0]   nsz, nsz_next;
  logic [ROW_W-1:0]   row, row_next;
  logic [ROW_W-1:0]   cand, cand_next;
  logic               started, started_next;
  logic               done, done_next;
  logic [ADDR_W-1:0]  chk, chk_next;
  logic [ADDR_W-1:0]  oidx, oidx_next;

  logic [TDATA_W-1:0] m_tdata_next;
  logic               m_tvalid_next, m_tlast_next, m_tuser_next;

  // column stack
  logic [ADDR_W-1:0]  stack [MAX_N];
  logic [ADDR_W-1:0]  raddr, waddr;
  logic [ADDR_W-1:0]  rdata, wdata;
  logic               mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack[waddr] <= wdata;
    end
    rdata <= stack[raddr];
  end

  // request decode
  logic [ROW_W-1:0] n_sat;
  logic [ROW_W-1:0] row_clamp;
  logic             fresh;

  always_comb begin
    if (EXT_W'(board_size) > EXT_W'(MAX_N)) begin
      n_sat = ROW_W'(MAX_N);
    end else begin
      n_sat = ROW_W'(board_size);
    end
    row_clamp = (row > n_sat) ? n_sat : row;
    fresh     = s_tdata[0] || !started;
  end

  // conflict test of cand against the queen read from row chk
  logic [ROW_W-1:0] qc, cdiff, rdiff;
  logic             conflict;

  always_comb begin
    qc       = ROW_W'(rdata);
    cdiff    = (cand > qc) ? (cand - qc) : (qc - cand);
    rdiff    = row - ROW_W'(chk);
    conflict = (cdiff == '0) || (cdiff == rdiff);
  end

  assign s_tready = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (fresh) begin
            state_next = (n_sat == '0) ? ST_EXH : ST_SEARCH;
          end else if (done || n_sat == '0) begin
            state_next = ST_EXH;
          end else if (row_clamp == n_sat) begin
            state_next = ST_POP;
          end else begin
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (row >= nsz) begin
          state_next = ST_OUT_RD;
        end else if (cand >= nsz) begin
          state_next = (row == '0) ? ST_EXH : ST_POP;
        end else if (row != '0) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (conflict || (ROW_W'(chk) + ROW_W'(1) >= row)) begin
          state_next = ST_SEARCH;
        end
      end
      ST_POP:    state_next = ST_SEARCH;
      ST_OUT_RD: state_next = ST_OUT_LD;
      ST_OUT_LD: state_next = ST_HOLD;
      ST_EXH:    state_next = ST_HOLD;
      ST_HOLD: begin
        if (m_tready) begin
          state_next = m_tlast ? ST_IDLE : ST_OUT_RD;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    nsz_next      = nsz;
    row_next      = row;
    cand_next     = cand;
    started_next  = started;
    done_next     = done;
    chk_next      = chk;
    oidx_next     = oidx;
    m_tvalid_next = m_tvalid;
    m_tdata_next  = m_tdata;
    m_tlast_next  = m_tlast;
    m_tuser_next  = m_tuser;
    mem_we        = 1'b0;
    waddr         = ADDR_W'(row);
    wdata         = ADDR_W'(cand);
    raddr         = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          nsz_next = n_sat;
          if (fresh) begin
            row_next     = '0;
            cand_next    = '0;
            started_next = 1'b1;
            done_next    = (n_sat == '0);
          end else if (!done) begin
            row_next = row_clamp;
            if (n_sat == '0) begin
              done_next = 1'b1;
            end else if (row_clamp == n_sat) begin
              // step back off the last solution
              row_next = row_clamp - ROW_W'(1);
              raddr    = ADDR_W'(row_clamp - ROW_W'(1));
            end
          end
        end
      end
      ST_SEARCH: begin
        oidx_next = '0;
        if (row >= nsz) begin
          // full placement: go to output
        end else if (cand >= nsz) begin
          if (row == '0) begin
            cand_next = '0;
            done_next = 1'b1;
          end else begin
            row_next = row - ROW_W'(1);
            raddr    = ADDR_W'(row - ROW_W'(1));
          end
        end else if (row == '0) begin
          mem_we    = 1'b1;
          row_next  = ROW_W'(1);
          cand_next = '0;
        end else begin
          chk_next = '0;
          raddr    = '0;
        end
      end
      ST_CHECK: begin
        if (conflict) begin
          cand_next = cand + ROW_W'(1);
        end else if (ROW_W'(chk) + ROW_W'(1) < row) begin
          chk_next = chk + ADDR_W'(1);
          raddr    = chk + ADDR_W'(1);
        end else begin
          mem_we    = 1'b1;
          row_next  = row + ROW_W'(1);
          cand_next = '0;
        end
      end
      ST_POP: begin
        cand_next = ROW_W'(rdata) + ROW_W'(1);
      end
      ST_OUT_RD: begin
        raddr = oidx;
      end
      ST_OUT_LD: begin
        m_tvalid_next = 1'b1;
        m_tdata_next  = {2'b00, 3'(rdata), 3'(oidx)};
        m_tlast_next  = (ROW_W'(oidx) == nsz - ROW_W'(1));
        m_tuser_next  = 1'b0;
      end
      ST_EXH: begin
        m_tvalid_next = 1'b1;
        m_tdata_next  = '0;
        m_tlast_next  = 1'b1;
        m_tuser_next  = 1'b1;
      end
      ST_HOLD: begin
        if (m_tready) begin
          m_tvalid_next = 1'b0;
          oidx_next     = oidx + ADDR_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      board_size <= BOARD_RESET;
      row        <= '0;
      cand       <= '0;
      started    <= 1'b0;
      done       <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      cand     <= cand_next;
      started  <= started_next;
      done     <= done_next;
      m_tvalid <= m_tvalid_next;
      if (cfg_we) begin
        board_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    nsz     <= nsz_next;
    chk     <= chk_next;
    oidx    <= oidx_next;
    m_tdata <= m_tdata_next;
    m_tlast <= m_tlast_next;
    m_tuser <= m_tuser_next;
  end

  // no new request while a result word is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input taken while output word pending");

  // stack written only while placing a queen
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_SEARCH || state == ST_CHECK))
    else $error("stack write outside search");

  // exhausted word is a single zero word with tlast
  a_exh_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && m_tdata == '0))
    else $error("malformed exhausted word");

  // a placement never grows beyond the board
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SEARCH) |-> (row <= nsz))
    else $error("row beyond board size");

endmodule
